// File: hdl/sdrt_pkg.sv
// Shared types, widths, reset values and codes of the dual output run timer.
// Used by every module in this folder but sdrt_ram; depends on nothing.

package sdrt_pkg;

	localparam int TIME_W          = 17;
	localparam int MS_W            = 24;
	localparam int DELTA_W         = 16;
	localparam int CNT_W           = 5;
	localparam int SLOT_W          = 4;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 24;
	localparam int DEF_MAX_ENTRIES = 16;

	localparam logic [TIME_W-1:0] RESET_PREV = 17'h1F000;
	localparam logic [MS_W-1:0]   DUR0_RST   = 24'd10000;
	localparam logic [MS_W-1:0]   DUR1_RST   = 24'd5000;

	// item kinds
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DUR0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUR1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CNT0 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CNT1 = 2'd3;

	typedef struct packed {
		logic [MS_W-1:0]  dur1;
		logic [MS_W-1:0]  dur0;
		logic [CNT_W-1:0] cnt1;
		logic [CNT_W-1:0] cnt0;
	} cfg_t;

	typedef struct packed {
		logic               opcode;
		logic               sel;
		logic [SLOT_W-1:0]  slot;
		logic [TIME_W-1:0]  tod;
		logic [DELTA_W-1:0] delta;
	} item_t;

	typedef struct packed {
		logic [1:0] run;
		logic [1:0] on;
		logic [1:0] off;
	} result_t;

endpackage

// File: hdl/sdrt_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Stand-alone; no package dependency.

module sdrt_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/sdrt_cfg.sv
// Configuration register bank: run durations and entry counts of both outputs.
// Depends on sdrt_pkg.

module sdrt_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sdrt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sdrt_pkg::CFG_DATA_W-1:0]  cfg_data,
	output sdrt_pkg::cfg_t                   cfg
);

	sdrt_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg         = cfg_q;

	// update the addressed register on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dur0 <= sdrt_pkg::DUR0_RST;
			cfg_q.dur1 <= sdrt_pkg::DUR1_RST;
			cfg_q.cnt0 <= '0;
			cfg_q.cnt1 <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sdrt_pkg::REG_DUR0: cfg_q.dur0 <= cfg_data[sdrt_pkg::MS_W-1:0];
				sdrt_pkg::REG_DUR1: cfg_q.dur1 <= cfg_data[sdrt_pkg::MS_W-1:0];
				sdrt_pkg::REG_CNT0: cfg_q.cnt0 <= cfg_data[sdrt_pkg::CNT_W-1:0];
				sdrt_pkg::REG_CNT1: cfg_q.cnt1 <= cfg_data[sdrt_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: hdl/sdrt_engine.sv
// Sequencer: trigger table RAM, table scan, run counters and result register.
// Depends on sdrt_pkg and sdrt_ram.

module sdrt_engine #(
	parameter int MAX_ENTRIES = sdrt_pkg::DEF_MAX_ENTRIES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sdrt_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  sdrt_pkg::item_t   in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output sdrt_pkg::result_t out_res
);

	localparam int IDXW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int AW    = IDXW + 1;
	localparam int DEPTH = 1 << AW;
	localparam int SW    = (IDXW > sdrt_pkg::SLOT_W) ? IDXW : sdrt_pkg::SLOT_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_UPD   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]                       state_q;
	logic [AW-1:0]                    addr_q;
	logic                             vld_s1;
	logic [AW-1:0]                    addr_s1;
	logic [1:0]                       hit_q;
	logic [1:0]                       running_q;
	logic [sdrt_pkg::MS_W-1:0]        elapsed_q [2];
	logic [sdrt_pkg::TIME_W-1:0]      prev_q;
	logic [sdrt_pkg::TIME_W-1:0]      now_q;
	logic [sdrt_pkg::DELTA_W-1:0]     delta_q;
	sdrt_pkg::result_t                res_q;
	sdrt_pkg::result_t                out_q;
	logic                             out_valid_q;

	logic                             in_acc;
	logic                             wr_en;
	logic [SW-1:0]                    slot_ext;
	logic [AW-1:0]                    wr_addr;
	logic                             rd_en;
	logic [sdrt_pkg::TIME_W-1:0]      rd_data;
	logic [IDXW-1:0]                  cmp_idx;
	logic                             cmp_out;
	logic [sdrt_pkg::CNT_W-1:0]       cmp_cnt;
	logic                             cmp_en;
	logic [sdrt_pkg::MS_W-1:0]        dur [2];
	logic [sdrt_pkg::CNT_W-1:0]       cnt [2];
	logic [sdrt_pkg::MS_W:0]          sum [2];
	logic [sdrt_pkg::MS_W-1:0]        sat [2];

	assign dur[0] = cfg.dur0;
	assign dur[1] = cfg.dur1;
	assign cnt[0] = cfg.cnt0;
	assign cnt[1] = cfg.cnt1;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// entry write address; slots past the table are dropped
	assign slot_ext = SW'(in_item.slot);
	assign wr_addr  = {in_item.sel, slot_ext[IDXW-1:0]};
	assign wr_en    = in_acc && (in_item.opcode == sdrt_pkg::OP_WRITE) &&
		(32'(in_item.slot) < 32'(MAX_ENTRIES));
	assign rd_en    = (state_q == ST_SCAN);

	sdrt_ram #(
		.WIDTH(sdrt_pkg::TIME_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(in_item.tod),
		.re   (rd_en),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	// an entry counts only if it is in use and its output is idle
	assign cmp_idx = addr_s1[IDXW-1:0];
	assign cmp_out = addr_s1[IDXW];
	assign cmp_cnt = cnt[cmp_out];
	assign cmp_en  = vld_s1 && !running_q[cmp_out] &&
		(32'(cmp_idx) < 32'(cmp_cnt)) && (32'(cmp_idx) < 32'(MAX_ENTRIES));

	// saturating run counters
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			sum[i] = {1'b0, elapsed_q[i]} + (sdrt_pkg::MS_W + 1)'(delta_q);
			sat[i] = sum[i][sdrt_pkg::MS_W] ? '1 : sum[i][sdrt_pkg::MS_W-1:0];
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			addr_q       <= '0;
			vld_s1       <= 1'b0;
			hit_q        <= '0;
			running_q    <= '0;
			elapsed_q[0] <= '0;
			elapsed_q[1] <= '0;
			prev_q       <= sdrt_pkg::RESET_PREV;
			out_valid_q  <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			if (cmp_en && (rd_data == prev_q || rd_data == now_q)) begin
				hit_q[cmp_out] <= 1'b1;
			end
			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_item.opcode == sdrt_pkg::OP_WRITE) begin
							state_q <= ST_OUT;
						end else begin
							addr_q  <= '0;
							hit_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == {AW{1'b1}}) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					for (int i = 0; i < 2; i++) begin
						if (running_q[i]) begin
							elapsed_q[i] <= sat[i];
							if (sat[i] >= dur[i]) begin
								running_q[i] <= 1'b0;
							end
						end else if (hit_q[i]) begin
							running_q[i] <= 1'b1;
							elapsed_q[i] <= '0;
						end
					end
					prev_q  <= now_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: scan pipeline address, tick operands, result staging
	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		if (in_acc && in_item.opcode == sdrt_pkg::OP_TICK) begin
			now_q   <= in_item.tod;
			delta_q <= in_item.delta;
		end
		if (in_acc && in_item.opcode == sdrt_pkg::OP_WRITE) begin
			res_q.run <= running_q;
			res_q.on  <= '0;
			res_q.off <= '0;
		end
		if (state_q == ST_UPD) begin
			for (int i = 0; i < 2; i++) begin
				res_q.on[i]  <= !running_q[i] && hit_q[i];
				res_q.off[i] <= running_q[i] && (sat[i] >= dur[i]);
				res_q.run[i] <= running_q[i] ? (sat[i] < dur[i]) : hit_q[i];
			end
		end
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_q <= res_q;
		end
	end

	a_on_runs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.on & ~out_q.run) == 2'b00))
		else $error("output switched on but not reported running");

	a_off_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.off & out_q.run) == 2'b00))
		else $error("output switched off but still reported running");

	a_on_off_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.on & out_q.off) == 2'b00))
		else $error("output switched on and off in one tick");

	a_tick_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_item.opcode == sdrt_pkg::OP_TICK) |=> (state_q == ST_SCAN))
		else $error("accepted tick did not start a table scan");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_IDLE))
		else $error("table written while a scan is in progress");

endmodule

// File: hdl/scheduled_dual_output_run_timer.sv
// Dual output run timer. Tick: after acceptance the engine scans both trigger tables
// through the one read port of the table RAM, then passes states DRAIN, UPD and OUT;
// OUT waits while an earlier result is untaken, and the next item is accepted only after OUT.
// Entry write: passes state OUT only; no new item is accepted until its result is valid.
// Reset (arst_n, asynchronous): outputs idle, counts zero, durations 10000/5000 ms,
// entry counts zero, previous time 31:00:00; table contents undefined until written.

module scheduled_dual_output_run_timer #(
	parameter int MAX_ENTRIES = sdrt_pkg::DEF_MAX_ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave side: tdata = slot, hour, minute, second, delta_ms (lowest first)
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [39:0]                      s_axis_tdata,
	// tuser = opcode, output_select (lowest first)
	input  logic [1:0]                       s_axis_tuser,
	// master side: tdata = running_mask, switched_on_mask, switched_off_mask
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [7:0]                       m_axis_tdata,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sdrt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sdrt_pkg::CFG_DATA_W-1:0]  cfg_data
);

	sdrt_pkg::cfg_t    cfg;
	sdrt_pkg::item_t   item;
	sdrt_pkg::result_t res;

	// unpack the input transaction
	assign item.opcode = s_axis_tuser[0];
	assign item.sel    = s_axis_tuser[1];
	assign item.slot   = s_axis_tdata[3:0];
	assign item.tod    = {s_axis_tdata[8:4], s_axis_tdata[14:9], s_axis_tdata[20:15]};
	assign item.delta  = s_axis_tdata[36:21];

	// pack the result transaction
	assign m_axis_tdata = {2'b00, res.off, res.on, res.run};

	sdrt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	sdrt_engine #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (item),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (res)
	);

endmodule
